>>> rtl/dwt2_daubechies4_one_level_unit_macros.svh
// Assertion macros for the db2 one-level wavelet unit.
`ifndef DWT2_DAUBECHIES4_ONE_LEVEL_UNIT_MACROS_SVH
`define DWT2_DAUBECHIES4_ONE_LEVEL_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge once reset is released.
`define DWT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DWT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DWT_ASSERT(lbl, clk, rst_n, prop, msg)
`define DWT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/dwt2d4_pkg.sv
// ----------------------------------------------------------------------------
// dwt2d4_pkg
// Shared widths, db2 coefficients, rounding helpers and the command/status
// types between the controller and the datapath.
// ----------------------------------------------------------------------------
package dwt2d4_pkg;

    localparam int MAX_WIDTH      = 4096;
    localparam int MIN_WIDTH      = 4;
    localparam int CNT_W          = $clog2(MAX_WIDTH);
    localparam int CFG_W          = 13;
    localparam int COL_W          = 11;
    localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 13'd1920;

    localparam int TAP_W          = 16;
    localparam int COEF_W         = 16;
    localparam int COEF_FRAC_BITS = 15;
    localparam int RSH            = COEF_FRAC_BITS - 2;
    localparam int V_W            = 19;
    localparam int B_W            = 22;
    localparam int VPROD_W        = TAP_W + COEF_W;
    localparam int VACC_W         = VPROD_W + 2;
    localparam int HPROD_W        = V_W + COEF_W;
    localparam int HACC_W         = HPROD_W + 2;

    // db2 filters in Q1.15, rounded half away from zero
    localparam logic signed [COEF_W-1:0] C_LO [4] = '{
        16'sd15826, 16'sd27411, 16'sd7345, -16'sd4240
    };
    localparam logic signed [COEF_W-1:0] C_HI [4] = '{
        -16'sd4240, -16'sd7345, 16'sd27411, -16'sd15826
    };

    // horizontal window arrangements
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_MID      = 2'd0;  // lw0 lw1 lw2 new
    localparam t_sel SEL_FIRST    = 2'd1;  // lw2 lw1 lw2 new (left mirror)
    localparam t_sel SEL_END_EVEN = 2'd2;  // lw1 lw2 new new
    localparam t_sel SEL_END_ODD  = 2'd3;  // lw2 new new lw2

    typedef struct packed {
        logic             cap_in;
        logic             vmul;
        logic             vsum;
        logic             hmul;
        logic             load;
        logic             shift;
        t_sel             sel;
        logic             last;
        logic [COL_W-1:0] col;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    localparam logic signed [VACC_W-1:0] VHALF = VACC_W'(1) <<< (RSH - 1);
    localparam logic signed [VACC_W-1:0] VMAX  = VACC_W'((1 << (V_W - 1)) - 1);
    localparam logic signed [VACC_W-1:0] VMIN  = -VMAX - VACC_W'(1);
    localparam logic signed [HACC_W-1:0] HHALF = HACC_W'(1) <<< (RSH - 1);
    localparam logic signed [HACC_W-1:0] HMAX  = HACC_W'((1 << (B_W - 1)) - 1);
    localparam logic signed [HACC_W-1:0] HMIN  = -HMAX - HACC_W'(1);

    // round half up, then saturate to V_W bits
    function automatic logic signed [V_W-1:0] vert_round(
        input logic signed [VACC_W-1:0] acc
    );
        logic signed [VACC_W-1:0] r;
        r = (acc + VHALF) >>> RSH;
        if (r > VMAX) begin
            r = VMAX;
        end else if (r < VMIN) begin
            r = VMIN;
        end
        return r[V_W-1:0];
    endfunction

    // round half up, then saturate to B_W bits
    function automatic logic signed [B_W-1:0] horz_round(
        input logic signed [HACC_W-1:0] acc
    );
        logic signed [HACC_W-1:0] r;
        r = (acc + HHALF) >>> RSH;
        if (r > HMAX) begin
            r = HMAX;
        end else if (r < HMIN) begin
            r = HMIN;
        end
        return r[B_W-1:0];
    endfunction

endpackage

>>> rtl/dwt2d4_ctrl.sv
// ----------------------------------------------------------------------------
// dwt2d4_ctrl
// Sequencer: column counting, row-width register, emission decisions and
// the step commands for the datapath.
// ----------------------------------------------------------------------------
`include "dwt2_daubechies4_one_level_unit_macros.svh"

module dwt2d4_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [12:0]               i_cfg_row_width,
    output dwt2d4_pkg::t_dp_cmd       o_cmd,
    input  dwt2d4_pkg::t_dp_stat      i_stat
);
    import dwt2d4_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_VMUL = 3'd1;
    localparam logic [2:0] S_VSUM = 3'd2;
    localparam logic [2:0] S_HMUL = 3'd3;
    localparam logic [2:0] S_HSUM = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CFG_W-1:0] r_row_width;
    logic             r_emit_a, n_emit_a;
    logic             r_emit_b, n_emit_b;
    logic             r_first, n_first;
    logic             r_phase_b, n_phase_b;
    logic [COL_W-1:0] r_k_a, n_k_a;

    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] w_m1;
    logic [CNT_W-1:0] col_j;
    logic             accept;
    logic [COL_W-1:0] k_b;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_row_width < CFG_W'(MIN_WIDTH)) begin
            w_eff = CFG_W'(MIN_WIDTH);
        end else if (r_row_width > CFG_W'(MAX_WIDTH)) begin
            w_eff = CFG_W'(MAX_WIDTH);
        end else begin
            w_eff = r_row_width;
        end
    end

    assign w_m1  = w_eff - CFG_W'(1);
    // a counter left beyond a narrowed width restarts the row
    assign col_j = (CFG_W'(r_count) >= w_eff) ? '0 : r_count;
    assign k_b   = w_m1[COL_W:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_row_width <= i_cfg_row_width;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_emit_a  = r_emit_a;
        n_emit_b  = r_emit_b;
        n_first   = r_first;
        n_phase_b = r_phase_b;
        n_k_a     = r_k_a;
        o_cmd     = '0;
        o_cmd.sel = r_phase_b ? (w_eff[0] ? SEL_END_ODD : SEL_END_EVEN)
                              : (r_first ? SEL_FIRST : SEL_MID);
        o_cmd.col  = r_phase_b ? k_b : r_k_a;
        o_cmd.last = r_phase_b || !r_emit_b;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.cap_in = 1'b1;
                    n_emit_a  = (col_j >= CNT_W'(2)) && !col_j[0];
                    n_emit_b  = (CFG_W'(col_j) == w_m1);
                    n_first   = (col_j == CNT_W'(2));
                    n_k_a     = col_j[COL_W:1] - COL_W'(1);
                    n_phase_b = 1'b0;
                    n_count   = (CFG_W'(col_j) == w_m1) ? '0 : col_j + CNT_W'(1);
                    n_state   = S_VMUL;
                end
            end
            S_VMUL: begin
                o_cmd.vmul = 1'b1;
                n_state    = S_VSUM;
            end
            S_VSUM: begin
                o_cmd.vsum = 1'b1;
                if (r_emit_a) begin
                    n_state = S_HMUL;
                end else if (r_emit_b) begin
                    n_phase_b = 1'b1;
                    n_state   = S_HMUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_HMUL: begin
                o_cmd.hmul = 1'b1;
                n_state    = S_HSUM;
            end
            S_HSUM: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    if (!r_phase_b && r_emit_b) begin
                        n_phase_b = 1'b1;
                        n_state   = S_HMUL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // window shift as the item retires; the vsum result is ready by then
        o_cmd.shift = (r_state == S_VSUM && !r_emit_a && !r_emit_b) ||
                      (r_state == S_HSUM && i_stat.out_free &&
                       (r_phase_b || !r_emit_b));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_emit_a  <= 1'b0;
            r_emit_b  <= 1'b0;
            r_first   <= 1'b0;
            r_phase_b <= 1'b0;
            r_k_a     <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_emit_a  <= n_emit_a;
            r_emit_b  <= n_emit_b;
            r_first   <= n_first;
            r_phase_b <= n_phase_b;
            r_k_a     <= n_k_a;
        end
    end

    `DWT_ASSERT(a_load_when_free, i_clk, i_rst_n, o_cmd.load |-> i_stat.out_free, "result loaded over an untaken result")
    `DWT_ASSERT(a_accept_starts, i_clk, i_rst_n, accept |=> (r_state == S_VMUL), "accepted item did not start the vertical step")
    `DWT_ASSERT(a_not_last_only_first, i_clk, i_rst_n, (o_cmd.load && !o_cmd.last) |-> (r_emit_b && !r_phase_b), "non-final result outside a two-result item")
    `DWT_ASSERT(a_shift_once, i_clk, i_rst_n, o_cmd.shift |=> (r_state == S_IDLE), "window shift did not retire the item")

endmodule

>>> rtl/dwt2d4_dp.sv
// ----------------------------------------------------------------------------
// dwt2d4_dp
// Arithmetic: vertical db2 filter pair, low/high column windows, horizontal
// filters for the four bands and the output register.
// ----------------------------------------------------------------------------
module dwt2d4_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dwt2d4_pkg::t_dp_cmd               i_cmd,
    output dwt2d4_pkg::t_dp_stat              o_stat,
    input  logic signed [15:0]                i_tap0,
    input  logic signed [15:0]                i_tap1,
    input  logic signed [15:0]                i_tap2,
    input  logic signed [15:0]                i_tap3,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [21:0]                o_band_a,
    output logic signed [21:0]                o_band_v,
    output logic signed [21:0]                o_band_h,
    output logic signed [21:0]                o_band_d,
    output logic [10:0]                       o_out_column,
    output logic                              o_last_of_run
);
    import dwt2d4_pkg::*;

    logic signed [TAP_W-1:0]   r_tap   [4];
    logic signed [VPROD_W-1:0] r_vp_lo [4];
    logic signed [VPROD_W-1:0] r_vp_hi [4];
    logic signed [V_W-1:0]     r_cl;
    logic signed [V_W-1:0]     r_ch;
    logic signed [V_W-1:0]     r_lw    [3];
    logic signed [V_W-1:0]     r_hw    [3];
    logic signed [HPROD_W-1:0] r_hp    [4][4];  // band, tap
    logic                      r_out_valid;
    logic signed [B_W-1:0]     r_band  [4];
    logic [COL_W-1:0]          r_col;
    logic                      r_last;

    logic signed [V_W-1:0]     tl [4];
    logic signed [V_W-1:0]     th [4];
    logic signed [VACC_W-1:0]  vacc_lo;
    logic signed [VACC_W-1:0]  vacc_hi;
    logic signed [V_W-1:0]     cl_new;
    logic signed [V_W-1:0]     ch_new;
    logic signed [HACC_W-1:0]  hacc [4];

    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        unique case (i_cmd.sel)
            SEL_MID: begin
                tl = '{r_lw[0], r_lw[1], r_lw[2], r_cl};
                th = '{r_hw[0], r_hw[1], r_hw[2], r_ch};
            end
            SEL_FIRST: begin
                tl = '{r_lw[2], r_lw[1], r_lw[2], r_cl};
                th = '{r_hw[2], r_hw[1], r_hw[2], r_ch};
            end
            SEL_END_EVEN: begin
                tl = '{r_lw[1], r_lw[2], r_cl, r_cl};
                th = '{r_hw[1], r_hw[2], r_ch, r_ch};
            end
            SEL_END_ODD: begin
                tl = '{r_lw[2], r_cl, r_cl, r_lw[2]};
                th = '{r_hw[2], r_ch, r_ch, r_hw[2]};
            end
        endcase
    end

    assign vacc_lo = VACC_W'(r_vp_lo[0]) + VACC_W'(r_vp_lo[1])
                   + VACC_W'(r_vp_lo[2]) + VACC_W'(r_vp_lo[3]);
    assign vacc_hi = VACC_W'(r_vp_hi[0]) + VACC_W'(r_vp_hi[1])
                   + VACC_W'(r_vp_hi[2]) + VACC_W'(r_vp_hi[3]);
    assign cl_new  = vert_round(vacc_lo);
    assign ch_new  = vert_round(vacc_hi);

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            hacc[b] = HACC_W'(r_hp[b][0]) + HACC_W'(r_hp[b][1])
                    + HACC_W'(r_hp[b][2]) + HACC_W'(r_hp[b][3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_tap[0] <= i_tap0;
            r_tap[1] <= i_tap1;
            r_tap[2] <= i_tap2;
            r_tap[3] <= i_tap3;
        end
        if (i_cmd.vmul) begin
            for (int i = 0; i < 4; i++) begin
                r_vp_lo[i] <= C_LO[i] * r_tap[i];
                r_vp_hi[i] <= C_HI[i] * r_tap[i];
            end
        end
        if (i_cmd.vsum) begin
            r_cl <= cl_new;
            r_ch <= ch_new;
        end
        if (i_cmd.hmul) begin
            for (int i = 0; i < 4; i++) begin
                r_hp[0][i] <= C_LO[i] * tl[i];
                r_hp[1][i] <= C_HI[i] * tl[i];
                r_hp[2][i] <= C_LO[i] * th[i];
                r_hp[3][i] <= C_HI[i] * th[i];
            end
        end
        if (i_cmd.load) begin
            for (int b = 0; b < 4; b++) begin
                r_band[b] <= horz_round(hacc[b]);
            end
            r_col  <= i_cmd.col;
            r_last <= i_cmd.last;
        end
    end

    // windows hold oldest first; zero after reset
    // a shift during the vertical step takes the fresh rounder output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_lw[i] <= '0;
                r_hw[i] <= '0;
            end
        end else if (i_cmd.shift) begin
            r_lw[0] <= r_lw[1];
            r_lw[1] <= r_lw[2];
            r_lw[2] <= i_cmd.vsum ? cl_new : r_cl;
            r_hw[0] <= r_hw[1];
            r_hw[1] <= r_hw[2];
            r_hw[2] <= i_cmd.vsum ? ch_new : r_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_band_a      = r_band[0];
    assign o_band_v      = r_band[1];
    assign o_band_h      = r_band[2];
    assign o_band_d      = r_band[3];
    assign o_out_column  = r_col;
    assign o_last_of_run = r_last;

endmodule

>>> rtl/dwt2_daubechies4_one_level_unit.sv
// ----------------------------------------------------------------------------
// dwt2_daubechies4_one_level_unit
// One-level 2-D db2 wavelet analysis on a stream of four-sample columns.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with i_tap0..i_tap3, one column of
// four vertically chosen samples per transfer. Output channel: o_out_valid /
// i_out_stall with the four bands A, V, H, D (Q.4), the output column and a
// flag on the last result of an input column.
// Configuration: i_cfg_valid / o_cfg_ready (always ready) writes row_width;
// write it only while no column is in flight.
// Sequence: a column is worked on alone by one shared sequencer. The vertical
// filter multiplies, then sums and rounds; each result then takes a multiply
// step and a sum-and-round step that loads the output register, the second
// result after the first. A new column is accepted only once the current one
// has loaded its last result, or has left the vertical filter if it has none.
// The output register lets the next column enter while the last result
// waits; a stalled receiver holds a result in place and the sequencer stops
// before loading the next one.
// Reset (synchronous, active low) clears the column counter and windows and
// sets row_width to 1920.
// ----------------------------------------------------------------------------
module dwt2_daubechies4_one_level_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [15:0]  i_tap0,
    input  logic signed [15:0]  i_tap1,
    input  logic signed [15:0]  i_tap2,
    input  logic signed [15:0]  i_tap3,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [21:0]  o_band_a,
    output logic signed [21:0]  o_band_v,
    output logic signed [21:0]  o_band_h,
    output logic signed [21:0]  o_band_d,
    output logic [10:0]         o_out_column,
    output logic                o_last_of_run,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [12:0]         i_cfg_row_width
);
    import dwt2d4_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dwt2d4_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_row_width (i_cfg_row_width),
        .o_cmd           (cmd),
        .i_stat          (stat)
    );

    dwt2d4_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_tap0        (i_tap0),
        .i_tap1        (i_tap1),
        .i_tap2        (i_tap2),
        .i_tap3        (i_tap3),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_band_a      (o_band_a),
        .o_band_v      (o_band_v),
        .o_band_h      (o_band_h),
        .o_band_d      (o_band_d),
        .o_out_column  (o_out_column),
        .o_last_of_run (o_last_of_run)
    );

endmodule
